// ===== hdl/sapc_pkg.sv =====
// Package: shared widths, types, command and status codes, saturation helper.
`default_nettype none

package sapc_pkg;

    // Width of the stored step position (8 to 32)
    localparam int POS_W   = 32;
    // Width of the value and position fields on the channels
    localparam int VALUE_W = 32;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    typedef logic signed [POS_W-1:0]   pos_t;
    typedef logic signed [VALUE_W-1:0] word_t;
    typedef logic signed [VALUE_W:0]   wide_t;
    typedef logic [OP_W-1:0]           op_t;
    typedef logic [STAT_W-1:0]         stat_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

    localparam op_t OP_TICK     = 3'd0;
    localparam op_t OP_ENABLE   = 3'd1;
    localparam op_t OP_DISABLE  = 3'd2;
    localparam op_t OP_MOVE_REL = 3'd3;
    localparam op_t OP_MOVE_ABS = 3'd4;
    localparam op_t OP_STOP     = 3'd5;
    localparam op_t OP_HOME     = 3'd6;
    localparam op_t OP_ZERO     = 3'd7;

    localparam stat_t ST_DISABLED   = 3'd0;
    localparam stat_t ST_IDLE       = 3'd1;
    localparam stat_t ST_MOVING     = 3'd2;
    localparam stat_t ST_HIT_TOP    = 3'd3;
    localparam stat_t ST_HIT_BOTTOM = 3'd4;

    localparam cfg_idx_t CFG_LIMITS_ACTIVE_LOW  = 2'd0;
    localparam cfg_idx_t CFG_DIRECTION_INVERTED = 2'd1;

    localparam wide_t POS_MAX = wide_t'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
    localparam wide_t POS_MIN = wide_t'(-((64'sd1 <<< (POS_W - 1))));

    // Saturate a wide signed value to the position range
    function automatic pos_t clamp_pos(input wide_t v);
        pos_t r;
        if (v > POS_MAX)
        begin
            r = pos_t'(POS_MAX);
        end
        else if (v < POS_MIN)
        begin
            r = pos_t'(POS_MIN);
        end
        else
        begin
            r = pos_t'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sapc_if.sv =====
// Interfaces: command, result and configuration channels.
`default_nettype none

interface sapc_cmd_if;
    logic                  valid;
    logic                  ready;
    sapc_pkg::op_t         op;
    sapc_pkg::word_t       value;
    logic                  step_due;
    logic                  top_limit_pin;
    logic                  bottom_limit_pin;

    modport source (output valid, op, value, step_due, top_limit_pin, bottom_limit_pin,
                    input ready);
    modport sink   (input valid, op, value, step_due, top_limit_pin, bottom_limit_pin,
                    output ready);
endinterface

interface sapc_res_if;
    logic                  valid;
    logic                  ready;
    logic                  step_pulse;
    logic                  dir_level;
    sapc_pkg::stat_t       status;
    sapc_pkg::word_t       position;
    sapc_pkg::word_t       target;
    logic                  busy_res;

    modport source (output valid, step_pulse, dir_level, status, position, target, busy_res,
                    input ready);
    modport sink   (input valid, step_pulse, dir_level, status, position, target, busy_res,
                    output ready);
endinterface

interface sapc_cfg_if;
    logic                  valid;
    logic                  ready;
    sapc_pkg::cfg_idx_t    index;
    sapc_pkg::cfg_data_t   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/stepper_axis_position_controller.sv =====
// Top level: single-axis step/direction position controller with limit homing.
`default_nettype none

//  channel | dir | word contents
//  --------+-----+---------------------------------------------------------------
//  cmd     | in  | op, value, step_due, top_limit_pin, bottom_limit_pin
//  res     | out | step_pulse, dir_level, status, position, target, busy_res
//  cfg     | in  | index (0 limits_active_low, 1 direction_inverted), data
//
//  The axis state and the result register load at the edge that accepts a command
//  word, so one word per clock is sustained while res is not stalled.
//  cmd.ready is low only while a result sits in the output register and res.ready
//  is low; a stall on res holds the result and the axis state.
//  Reset: position and target zero, driver disabled, direction up, limits active low.
//  cfg is always ready; writes to index 2 and 3 are dropped.

module stepper_axis_position_controller
(
    input  wire            clk,
    input  wire            rst_n,
    sapc_cmd_if.sink       cmd,
    sapc_res_if.source     res,
    sapc_cfg_if.sink       cfg
);

    // Configuration
    logic limits_active_low_reg;
    logic direction_inverted_reg;

    // Axis state
    sapc_pkg::pos_t  pos_reg,    pos_next;
    sapc_pkg::pos_t  tgt_reg,    tgt_next;
    logic            en_reg,     en_next;
    logic            homing_reg, homing_next;
    sapc_pkg::stat_t status_reg, status_next;
    logic            up_reg,     up_next;

    // Result register
    logic            res_valid_reg;
    logic            res_pulse_reg;
    logic            res_dir_reg;
    sapc_pkg::stat_t res_status_reg;
    sapc_pkg::word_t res_pos_reg;
    sapc_pkg::word_t res_tgt_reg;

    logic            pulse_next;
    logic            top_pressed;
    logic            bottom_pressed;
    logic            want_up;
    logic            cmd_fire;
    sapc_pkg::wide_t rel_sum;

    assign cfg.ready = 1'b1;

    // Take a word when the result slot is free or being emptied this cycle
    assign cmd.ready = !res_valid_reg || res.ready;
    assign cmd_fire  = cmd.valid && cmd.ready;

    // Pin level equals pressed unless the switches are active low
    assign top_pressed    = cmd.top_limit_pin ^ limits_active_low_reg;
    assign bottom_pressed = cmd.bottom_limit_pin ^ limits_active_low_reg;

    assign want_up = tgt_reg > pos_reg;
    assign rel_sum = sapc_pkg::wide_t'(pos_reg) + sapc_pkg::wide_t'(cmd.value);

    always_comb
    begin
        pos_next    = pos_reg;
        tgt_next    = tgt_reg;
        en_next     = en_reg;
        homing_next = homing_reg;
        status_next = status_reg;
        up_next     = up_reg;
        pulse_next  = 1'b0;

        case (cmd.op)
            sapc_pkg::OP_TICK:
            begin
                if (!en_reg)
                begin
                    status_next = sapc_pkg::ST_DISABLED;
                end
                else if (homing_reg)
                begin
                    if (bottom_pressed)
                    begin
                        // Home found: this is the new origin
                        homing_next = 1'b0;
                        pos_next    = '0;
                        tgt_next    = '0;
                        status_next = sapc_pkg::ST_HIT_BOTTOM;
                    end
                    else
                    begin
                        up_next = 1'b0;
                        if (cmd.step_due)
                        begin
                            pulse_next  = 1'b1;
                            // Hold at the lowest position, the pulse still goes out
                            if (sapc_pkg::wide_t'(pos_reg) > sapc_pkg::POS_MIN)
                            begin
                                pos_next = pos_reg - sapc_pkg::pos_t'(1);
                            end
                            status_next = sapc_pkg::ST_MOVING;
                        end
                    end
                end
                else if (pos_reg == tgt_reg)
                begin
                    status_next = sapc_pkg::ST_IDLE;
                end
                else if ((want_up && top_pressed) || (!want_up && bottom_pressed))
                begin
                    // Blocked by a limit: latch the hit and drop the remaining move
                    status_next = want_up ? sapc_pkg::ST_HIT_TOP : sapc_pkg::ST_HIT_BOTTOM;
                    tgt_next    = pos_reg;
                end
                else
                begin
                    up_next = want_up;
                    if (cmd.step_due)
                    begin
                        pulse_next = 1'b1;
                        pos_next   = want_up ? pos_reg + sapc_pkg::pos_t'(1)
                                             : pos_reg - sapc_pkg::pos_t'(1);
                    end
                    status_next = sapc_pkg::ST_MOVING;
                end
            end
            sapc_pkg::OP_ENABLE:
            begin
                en_next     = 1'b1;
                status_next = sapc_pkg::ST_IDLE;
            end
            sapc_pkg::OP_DISABLE:
            begin
                en_next     = 1'b0;
                homing_next = 1'b0;
                status_next = sapc_pkg::ST_DISABLED;
            end
            sapc_pkg::OP_MOVE_REL:
            begin
                if (cmd.value != '0)
                begin
                    homing_next = 1'b0;
                    tgt_next    = sapc_pkg::clamp_pos(rel_sum);
                    en_next     = 1'b1;
                    status_next = sapc_pkg::ST_MOVING;
                end
            end
            sapc_pkg::OP_MOVE_ABS:
            begin
                homing_next = 1'b0;
                tgt_next    = sapc_pkg::clamp_pos(sapc_pkg::wide_t'(cmd.value));
                if (!en_reg)
                begin
                    en_next     = 1'b1;
                    status_next = sapc_pkg::ST_IDLE;
                end
                if (pos_reg != tgt_next)
                begin
                    status_next = sapc_pkg::ST_MOVING;
                end
            end
            sapc_pkg::OP_STOP:
            begin
                tgt_next    = pos_reg;
                homing_next = 1'b0;
                if (en_reg)
                begin
                    status_next = sapc_pkg::ST_IDLE;
                end
            end
            sapc_pkg::OP_HOME:
            begin
                homing_next = 1'b1;
                tgt_next    = pos_reg;
                en_next     = 1'b1;
                status_next = sapc_pkg::ST_MOVING;
            end
            sapc_pkg::OP_ZERO:
            begin
                pos_next = '0;
                tgt_next = '0;
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_active_low_reg  <= 1'b1;
            direction_inverted_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == sapc_pkg::CFG_LIMITS_ACTIVE_LOW)
            begin
                limits_active_low_reg <= cfg.data[0];
            end
            else if (cfg.index == sapc_pkg::CFG_DIRECTION_INVERTED)
            begin
                direction_inverted_reg <= cfg.data[0];
            end
        end
    end

    // Axis state: advance on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            tgt_reg    <= '0;
            en_reg     <= 1'b0;
            homing_reg <= 1'b0;
            status_reg <= sapc_pkg::ST_DISABLED;
            up_reg     <= 1'b1;
        end
        else if (cmd_fire)
        begin
            pos_reg    <= pos_next;
            tgt_reg    <= tgt_next;
            en_reg     <= en_next;
            homing_reg <= homing_next;
            status_reg <= status_next;
            up_reg     <= up_next;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload: load with the accepted word, hold while stalled
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            res_pulse_reg  <= pulse_next;
            res_dir_reg    <= up_next ^ direction_inverted_reg;
            res_status_reg <= status_next;
            res_pos_reg    <= sapc_pkg::word_t'(pos_next);
            res_tgt_reg    <= sapc_pkg::word_t'(tgt_next);
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.step_pulse = res_pulse_reg;
    assign res.dir_level  = res_dir_reg;
    assign res.status     = res_status_reg;
    assign res.position   = res_pos_reg;
    assign res.target     = res_tgt_reg;
    assign res.busy_res   = (res_status_reg == sapc_pkg::ST_MOVING);

endmodule

`default_nettype wire

// ===== tb/sv/stepper_axis_position_controller_test.sv =====
// Testbench for the step/direction axis controller: predicts every result word and checks it.
module stepper_axis_position_controller_test;

    import sapc_pkg::*;

    // Cycles with no word moving on any channel before the run is declared hung
    localparam int HANG_LIMIT = 2000;
    // Cycles to let the result register settle after the last expected word
    localparam int SETTLE_CYCLES = 4;
    // Words per random phase; four phases make up the bulk of the run
    localparam int PHASE_WORDS = 475;

    // Register indexes past the end of the map; the block must drop these writes
    localparam cfg_idx_t CFG_SPARE_2 = 2'd2;
    localparam cfg_idx_t CFG_SPARE_3 = 2'd3;

    localparam longint AXIS_MAX = (longint'(1) <<< (POS_W - 1)) - 1;
    localparam longint AXIS_MIN = -AXIS_MAX - 1;

    localparam word_t WORD_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};

    typedef struct packed {
        op_t   op;
        word_t value;
        logic  step_due;
        logic  top_pin;
        logic  bottom_pin;
    } axis_cmd_t;

    typedef struct packed {
        logic  step_pulse;
        logic  dir_level;
        stat_t status;
        word_t position;
        word_t target;
        logic  busy;
    } axis_res_t;

    logic clk;
    logic rst_n;

    sapc_cmd_if cmd_ch();
    sapc_res_if res_ch();
    sapc_cfg_if cfg_ch();

    stepper_axis_position_controller dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // Axis state as the block should hold it
    pos_t  axis_pos;
    pos_t  axis_target;
    bit    axis_enabled;
    bit    axis_homing;
    bit    axis_dir_up;
    stat_t axis_status;
    // Register copies
    bit    lim_active_low;
    bit    dir_inverted;

    axis_cmd_t cmd_backlog[$];
    axis_res_t expected_results[$];

    bit cmd_taken;
    bit quiet_tail;
    int send_gap;
    int stall_left;
    int hang_count;
    int failures;

    always
    begin
        #2 clk = ~clk;
    end

    // Apply one command word to the axis state and return the result word it causes
    function automatic axis_res_t advance_axis(axis_cmd_t c);
        axis_res_t r;
        bit        top_hit;
        bit        bottom_hit;
        bit        pulse;
        bit        up;
        longint    goal;
        top_hit    = lim_active_low ? !c.top_pin : c.top_pin;
        bottom_hit = lim_active_low ? !c.bottom_pin : c.bottom_pin;
        pulse      = 1'b0;
        case (c.op)
            OP_TICK:
            begin
                if (!axis_enabled)
                begin
                    axis_status = ST_DISABLED;
                end
                else if (axis_homing)
                begin
                    if (bottom_hit)
                    begin
                        // Homed: the bottom switch defines zero
                        axis_homing = 1'b0;
                        axis_pos    = '0;
                        axis_target = '0;
                        axis_status = ST_HIT_BOTTOM;
                    end
                    else
                    begin
                        axis_dir_up = 1'b0;
                        if (c.step_due)
                        begin
                            pulse = 1'b1;
                            // Hold at the lowest position but still pulse
                            if (longint'(axis_pos) > AXIS_MIN)
                            begin
                                axis_pos = axis_pos - 1;
                            end
                            axis_status = ST_MOVING;
                        end
                    end
                end
                else if (axis_pos == axis_target)
                begin
                    axis_status = ST_IDLE;
                end
                else
                begin
                    up = axis_target > axis_pos;
                    if ((up && top_hit) || (!up && bottom_hit))
                    begin
                        // Blocked by a switch: drop the rest of the move
                        axis_status = up ? ST_HIT_TOP : ST_HIT_BOTTOM;
                        axis_target = axis_pos;
                    end
                    else
                    begin
                        axis_dir_up = up;
                        if (c.step_due)
                        begin
                            pulse    = 1'b1;
                            axis_pos = up ? axis_pos + 1 : axis_pos - 1;
                        end
                        axis_status = ST_MOVING;
                    end
                end
            end
            OP_ENABLE:
            begin
                axis_enabled = 1'b1;
                axis_status  = ST_IDLE;
            end
            OP_DISABLE:
            begin
                axis_enabled = 1'b0;
                axis_homing  = 1'b0;
                axis_status  = ST_DISABLED;
            end
            OP_MOVE_REL:
            begin
                // A zero step count leaves everything as it is
                if (c.value != 0)
                begin
                    axis_homing = 1'b0;
                    goal = longint'(axis_pos) + longint'(c.value);
                    if (goal > AXIS_MAX)
                    begin
                        goal = AXIS_MAX;
                    end
                    else if (goal < AXIS_MIN)
                    begin
                        goal = AXIS_MIN;
                    end
                    axis_target  = pos_t'(goal);
                    axis_enabled = 1'b1;
                    axis_status  = ST_MOVING;
                end
            end
            OP_MOVE_ABS:
            begin
                axis_homing = 1'b0;
                goal = longint'(c.value);
                if (goal > AXIS_MAX)
                begin
                    goal = AXIS_MAX;
                end
                else if (goal < AXIS_MIN)
                begin
                    goal = AXIS_MIN;
                end
                axis_target = pos_t'(goal);
                if (!axis_enabled)
                begin
                    axis_enabled = 1'b1;
                    axis_status  = ST_IDLE;
                end
                if (axis_pos != axis_target)
                begin
                    axis_status = ST_MOVING;
                end
            end
            OP_STOP:
            begin
                axis_target = axis_pos;
                axis_homing = 1'b0;
                if (axis_enabled)
                begin
                    axis_status = ST_IDLE;
                end
            end
            OP_HOME:
            begin
                axis_homing  = 1'b1;
                axis_target  = axis_pos;
                axis_enabled = 1'b1;
                axis_status  = ST_MOVING;
            end
            default:
            begin
                // Zero keeps the status as it is
                axis_pos    = '0;
                axis_target = '0;
            end
        endcase
        r.step_pulse = pulse;
        r.dir_level  = axis_dir_up ^ dir_inverted;
        r.status     = axis_status;
        r.position   = word_t'(axis_pos);
        r.target     = word_t'(axis_target);
        r.busy       = (axis_status == ST_MOVING);
        return r;
    endfunction

    // Pin level for a switch that is or is not pressed under the current polarity
    function automatic bit pin_level(bit pressed);
        return lim_active_low ? !pressed : pressed;
    endfunction

    function automatic word_t pick_value();
        word_t v;
        case ($urandom_range(0, 9))
            0:       v = word_t'($urandom());
            1:       v = WORD_MAX;
            2:       v = WORD_MIN;
            3:       v = '0;
            default: v = word_t'($urandom_range(0, 48)) - 24;
        endcase
        return v;
    endfunction

    function automatic void queue_word(op_t op, word_t v, bit due, bit top, bit bottom);
        axis_cmd_t c;
        c.op         = op;
        c.value      = v;
        c.step_due   = due;
        c.top_pin    = top;
        c.bottom_pin = bottom;
        cmd_backlog.push_back(c);
    endfunction

    // Mostly a command followed by a run of ticks, so moves and homing play out;
    // the rest is unconstrained noise
    function automatic void queue_random_words(int count);
        int added;
        int run;
        int k;
        added = 0;
        while (added < count)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 5))
                    0, 1:    queue_word(OP_MOVE_REL, pick_value(), 1'b0, 1'b0, 1'b0);
                    2:       queue_word(OP_MOVE_ABS, pick_value(), 1'b1, 1'b1, 1'b1);
                    3:       queue_word(OP_HOME, word_t'($urandom()), 1'b0, 1'b1, 1'b0);
                    4:       queue_word(OP_ENABLE, word_t'($urandom()), 1'b1, 1'b0, 1'b1);
                    default: queue_word(OP_ZERO, word_t'($urandom()), 1'b0, 1'b0, 1'b0);
                endcase
                run = $urandom_range(1, 16);
                for (k = 0; k < run; k++)
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        queue_word(op_t'($urandom_range(OP_ENABLE, OP_ZERO)), pick_value(),
                                   $urandom_range(0, 1), $urandom_range(0, 1),
                                   $urandom_range(0, 1));
                    end
                    else
                    begin
                        queue_word(OP_TICK, word_t'($urandom()), $urandom_range(0, 3) != 0,
                                   pin_level($urandom_range(0, 11) == 0),
                                   pin_level($urandom_range(0, 11) == 0));
                    end
                end
                added += 1 + run;
            end
            else
            begin
                queue_word(op_t'($urandom_range(OP_TICK, OP_ZERO)), pick_value(),
                           $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
                added++;
            end
        end
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // Write one register; the predictor copy follows at the accepting edge
    task automatic write_setting(cfg_idx_t idx, cfg_data_t d);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        case (idx)
            CFG_LIMITS_ACTIVE_LOW:  lim_active_low = d;
            CFG_DIRECTION_INVERTED: dir_inverted   = d;
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Hold until every queued word is sent and every expected result is back,
    // then give the result register time to show anything stray
    task automatic wait_for_idle();
        while (cmd_backlog.size() != 0 || cmd_ch.valid || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Command driver: advance to the next word once the current one is taken,
    // with random bursts of idle cycles between words
    always @(negedge clk)
    begin
        axis_cmd_t next_word;
        if (rst_n && (!cmd_ch.valid || cmd_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                cmd_ch.valid <= 1'b0;
            end
            else if (!quiet_tail && cmd_backlog.size() != 0 && $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(1, 12) - 1;
                cmd_ch.valid <= 1'b0;
            end
            else if (cmd_backlog.size() != 0)
            begin
                next_word = cmd_backlog.pop_front();
                cmd_ch.op               <= next_word.op;
                cmd_ch.value            <= next_word.value;
                cmd_ch.step_due         <= next_word.step_due;
                cmd_ch.top_limit_pin    <= next_word.top_pin;
                cmd_ch.bottom_limit_pin <= next_word.bottom_pin;
                cmd_ch.valid            <= 1'b1;
            end
            else
            begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Result sink: stall in random bursts, never in the quiet tail
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end
        else if (!quiet_tail && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 12) - 1;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
        end
    end

    // Monitor: predict on every accepted command word, check every accepted result word
    always @(posedge clk)
    begin
        axis_cmd_t taken;
        axis_res_t seen;
        axis_res_t want;
        cmd_taken = rst_n && cmd_ch.valid && cmd_ch.ready;
        if (cmd_taken)
        begin
            taken.op         = cmd_ch.op;
            taken.value      = cmd_ch.value;
            taken.step_due   = cmd_ch.step_due;
            taken.top_pin    = cmd_ch.top_limit_pin;
            taken.bottom_pin = cmd_ch.bottom_limit_pin;
            expected_results.push_back(advance_axis(taken));
        end
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            seen.step_pulse = res_ch.step_pulse;
            seen.dir_level  = res_ch.dir_level;
            seen.status     = res_ch.status;
            seen.position   = res_ch.position;
            seen.target     = res_ch.target;
            seen.busy       = res_ch.busy_res;
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing expected");
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("step_pulse", want.step_pulse, seen.step_pulse);
                check_field("dir_level", want.dir_level, seen.dir_level);
                check_field("status", want.status, seen.status);
                check_field("position", $signed(want.position), $signed(seen.position));
                check_field("target", $signed(want.target), $signed(seen.target));
                check_field("busy_res", want.busy, seen.busy);
            end
        end
    end

    // Hang detector: any word on any channel restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
            begin
                hang_count = 0;
            end
            else
            begin
                hang_count++;
            end
            if (hang_count >= HANG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int phase;
        clk   = 1'b0;
        rst_n = 1'b0;
        cmd_ch.valid            = 1'b0;
        cmd_ch.op               = OP_TICK;
        cmd_ch.value            = '0;
        cmd_ch.step_due         = 1'b0;
        cmd_ch.top_limit_pin    = 1'b1;
        cmd_ch.bottom_limit_pin = 1'b1;
        res_ch.ready            = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = CFG_LIMITS_ACTIVE_LOW;
        cfg_ch.data             = 1'b1;

        // Predictor starts from the reset state
        axis_pos       = '0;
        axis_target    = '0;
        axis_enabled   = 1'b0;
        axis_homing    = 1'b0;
        axis_dir_up    = 1'b1;
        axis_status    = ST_DISABLED;
        lim_active_low = 1'b1;
        dir_inverted   = 1'b0;
        cmd_taken      = 1'b0;
        quiet_tail     = 1'b0;
        send_gap       = 0;
        stall_left     = 0;
        hang_count     = 0;
        failures       = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, reset polarity: switches active low, so pin 1 is released
        queue_word(OP_TICK, '0, 1'b1, 1'b1, 1'b1);          // tick while disabled
        queue_word(OP_MOVE_REL, '0, 1'b0, 1'b1, 1'b1);      // zero step count is ignored
        queue_word(OP_STOP, '0, 1'b0, 1'b1, 1'b1);          // stop while disabled
        queue_word(OP_ENABLE, '0, 1'b0, 1'b1, 1'b1);
        queue_word(OP_MOVE_ABS, 32'sd3, 1'b0, 1'b1, 1'b1);
        queue_word(OP_TICK, '0, 1'b1, 1'b1, 1'b1);
        queue_word(OP_TICK, '0, 1'b1, 1'b1, 1'b1);
        queue_word(OP_TICK, '0, 1'b0, 1'b1, 1'b1);          // moving, no step due
        queue_word(OP_TICK, '0, 1'b1, 1'b0, 1'b1);          // top switch blocks the move
        queue_word(OP_TICK, '0, 1'b1, 1'b1, 1'b1);          // at target: idle
        queue_word(OP_MOVE_REL, WORD_MAX, 1'b0, 1'b1, 1'b1); // target saturates high
        queue_word(OP_TICK, '0, 1'b1, 1'b1, 1'b1);
        queue_word(OP_STOP, '0, 1'b0, 1'b1, 1'b1);
        queue_word(OP_HOME, '0, 1'b0, 1'b1, 1'b1);
        queue_word(OP_TICK, '0, 1'b1, 1'b1, 1'b1);          // homing step down
        queue_word(OP_TICK, '0, 1'b0, 1'b1, 1'b1);          // homing, no step due
        queue_word(OP_TICK, '0, 1'b1, 1'b1, 1'b0);          // bottom switch zeroes the axis
        queue_word(OP_HOME, '0, 1'b0, 1'b1, 1'b1);
        queue_word(OP_TICK, '0, 1'b1, 1'b0, 1'b1);          // top switch ignored while homing
        queue_word(OP_ENABLE, '0, 1'b0, 1'b1, 1'b1);        // enable keeps homing
        queue_word(OP_TICK, '0, 1'b1, 1'b1, 1'b1);
        queue_word(OP_MOVE_REL, WORD_MIN, 1'b0, 1'b1, 1'b1); // target saturates low
        queue_word(OP_TICK, '0, 1'b1, 1'b1, 1'b0);          // bottom switch blocks the move
        queue_word(OP_MOVE_ABS, WORD_MAX, 1'b0, 1'b1, 1'b1);
        queue_word(OP_ZERO, '0, 1'b0, 1'b1, 1'b1);
        queue_word(OP_MOVE_ABS, '0, 1'b0, 1'b1, 1'b1);      // target already reached
        queue_word(OP_DISABLE, '0, 1'b0, 1'b1, 1'b1);
        queue_word(OP_HOME, WORD_MIN, 1'b0, 1'b0, 1'b0);    // home turns the driver on
        wait_for_idle();

        // Random phases, each under its own register setting; the sender
        // holds at every phase boundary until all results are back
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_setting(CFG_LIMITS_ACTIVE_LOW, 1'b0);
                    write_setting(CFG_DIRECTION_INVERTED, 1'b1);
                    write_setting(CFG_SPARE_2, 1'b1);
                    write_setting(CFG_SPARE_3, 1'b0);
                end
                1:
                begin
                    write_setting(CFG_DIRECTION_INVERTED, 1'b0);
                    write_setting(CFG_SPARE_3, 1'b1);
                    write_setting(CFG_SPARE_2, 1'b0);
                end
                2:
                begin
                    write_setting(CFG_LIMITS_ACTIVE_LOW, 1'b1);
                    write_setting(CFG_DIRECTION_INVERTED, 1'b1);
                end
                default:
                begin
                    write_setting(CFG_DIRECTION_INVERTED, 1'b0);
                    // Run the tail at full rate on both sides
                    quiet_tail = 1'b1;
                end
            endcase
            queue_random_words(PHASE_WORDS);
            wait_for_idle();
        end

        if (failures == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
